### rtl/dominant_color_pixel_classifier_top_assert.svh
// Assertion macros for the pixel classifier.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef DOMINANT_COLOR_PIXEL_CLASSIFIER_TOP_ASSERT_SVH
`define DOMINANT_COLOR_PIXEL_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, ignored while in reset
`define DCPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcpc assertion failed");

// Next-cycle implication, ignored while in reset
`define DCPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcpc assertion failed");

`endif

### rtl/dcpc_pkg.sv
// Shared types and constants for the dominant colour pixel classifier.
// No dependencies.
package dcpc_pkg;

    // Transaction kinds carried in tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Register map (index = paddr[3:2])
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_LEVEL = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_ORDER = 2'd2;

    localparam logic [7:0]  LEVEL_RST = 8'd75;
    localparam logic [2:0]  COUNT_RST = 3'd1;
    localparam logic [14:0] ORDER_RST = 15'd0;

    localparam int NUM_CLASSES = 5;
    localparam logic [2:0] CODE_NONE = 3'd0;
    localparam logic [2:0] CODE_MAX  = 3'd5;

    // Per class: main channel, the two compared channels, ratios in hundredths
    localparam logic [1:0] CLS_M [NUM_CLASSES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2};
    localparam logic [1:0] CLS_P [NUM_CLASSES] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0};
    localparam logic [1:0] CLS_Q [NUM_CLASSES] = '{2'd2, 2'd0, 2'd1, 2'd0, 2'd1};
    localparam logic [7:0] CLS_RP [NUM_CLASSES] = '{8'd122, 8'd115, 8'd115, 8'd80, 8'd60};
    localparam logic [7:0] CLS_RQ [NUM_CLASSES] = '{8'd150, 8'd115, 8'd115, 8'd112, 8'd105};
    localparam logic [15:0] PCT = 16'd100;

    // Forced output colour per class, {out2, out1, out0}
    localparam logic [23:0] CLS_COLOUR [NUM_CLASSES] = '{
        24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFF00, 24'hFF00FF
    };

    // Column top entry: valid mark and topmost class-0 row
    typedef struct packed {
        logic       valid;
        logic [7:0] top;
    } col_entry_t;

    // Colour for a stored code; zero for no match
    function automatic logic [23:0] colour_of(input logic [2:0] code);
        logic [23:0] c;
        c = 24'd0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (code == 3'(i + 1))
            begin
                c = CLS_COLOUR[i];
            end
        end
        return c;
    endfunction

endpackage

### rtl/dominant_color_pixel_classifier_top.sv
// Dominant colour pixel classifier: three-stage pipeline around two memories.
// A read transaction's result passes through stage 1, stage 2 and the output register to m_axis.
// Throughput: one transaction per cycle; input stalls only while a read result in the last
// stage waits behind an output register still held by the sink.
// Reset clears the pipeline valid flags and the configuration registers; memories are not cleared.
// Depends on dcpc_pkg and dominant_color_pixel_classifier_top_assert.svh.
`include "dominant_color_pixel_classifier_top_assert.svh"

module dominant_color_pixel_classifier_top
    import dcpc_pkg::*;
#(
    parameter int FRAME_ROWS = 240,
    parameter int FRAME_COLS = 320
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [47:0]       s_axis_tdata,  // row[7:0], col[16:8], chan0, chan1, chan2, pad
    input  logic              s_axis_tuser,  // action
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // class_code[2:0], out0, out1, out2, pad
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int PIX_DEPTH = FRAME_ROWS * FRAME_COLS;
    localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int COL_AW    = (FRAME_COLS > 1) ? $clog2(FRAME_COLS) : 1;
    localparam int COL_XW    = (COL_AW > 9) ? COL_AW : 9;

    // ---------------- configuration registers ----------------
    logic [7:0]  level_reg;
    logic [2:0]  count_reg;
    logic [14:0] order_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_RST;
            count_reg <= COUNT_RST;
            order_reg <= ORDER_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_LEVEL: level_reg <= pwdata[7:0];
                REG_COUNT: count_reg <= pwdata[2:0];
                REG_ORDER: order_reg <= pwdata[14:0];
                default:   ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_LEVEL: prdata = {24'd0, level_reg};
            REG_COUNT: prdata = {29'd0, count_reg};
            REG_ORDER: prdata = {17'd0, order_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic        adv;
    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [7:0]  s1_row_reg;
    logic [8:0]  s1_col_reg;
    logic [7:0]  s1_ch_reg [3];

    logic        s2_valid_reg;
    logic        s2_action_reg;
    logic        s2_inside_reg;
    logic [7:0]  s2_row_reg;
    logic [COL_AW-1:0] s2_col_reg;
    logic [2:0]  s2_code_reg;

    logic        m_valid_reg;
    logic [31:0] m_data_reg;

    // Everything moves unless a read result is blocked by a full output register
    assign adv = !s2_valid_reg || (s2_action_reg == ACT_WRITE) || !m_valid_reg
                 || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage 1 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_action_reg <= s_axis_tuser;
            s1_row_reg    <= s_axis_tdata[7:0];
            s1_col_reg    <= s_axis_tdata[16:8];
            s1_ch_reg[0]  <= s_axis_tdata[24:17];
            s1_ch_reg[1]  <= s_axis_tdata[32:25];
            s1_ch_reg[2]  <= s_axis_tdata[40:33];
        end
    end

    // ---------------- stage 1: classify and address ----------------
    logic [7:0]        match;
    logic [2:0]        s1_code;
    logic              s1_found;
    logic              s1_inside;
    logic [PIX_AW-1:0] s1_pix_addr;
    logic [COL_XW-1:0] s1_col_ext;
    logic [COL_AW-1:0] s1_col_idx;

    // Per-class ratio tests, all with constant multipliers
    always_comb
    begin
        match = 8'd0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            match[c] = (s1_ch_reg[CLS_M[c]] > level_reg)
                && (16'(s1_ch_reg[CLS_M[c]]) * PCT > 16'(CLS_RP[c]) * 16'(s1_ch_reg[CLS_P[c]]))
                && (16'(s1_ch_reg[CLS_M[c]]) * PCT > 16'(CLS_RQ[c]) * 16'(s1_ch_reg[CLS_Q[c]]));
        end
    end

    // First match in the configured order; class numbers above 4 never match
    always_comb
    begin
        s1_code  = CODE_NONE;
        s1_found = 1'b0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            if (!s1_found && (3'(k) < count_reg) && match[order_reg[3*k +: 3]])
            begin
                s1_code  = order_reg[3*k +: 3] + 3'd1;
                s1_found = 1'b1;
            end
        end
    end

    assign s1_inside   = (32'(s1_row_reg) < FRAME_ROWS) && (32'(s1_col_reg) < FRAME_COLS);
    assign s1_pix_addr = PIX_AW'(32'(s1_row_reg) * FRAME_COLS + 32'(s1_col_reg));
    assign s1_col_ext  = COL_XW'(s1_col_reg);
    assign s1_col_idx  = s1_col_ext[COL_AW-1:0];

    // Pixel code memory: one access per cycle while the pipeline advances, write or read of the stage-1 item
    logic [2:0] pix_mem [PIX_DEPTH];
    logic [2:0] pix_rd_reg;

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg && s1_inside)
        begin
            if (s1_action_reg == ACT_WRITE)
            begin
                pix_mem[s1_pix_addr] <= s1_code;
            end
            else
            begin
                pix_rd_reg <= pix_mem[s1_pix_addr];
            end
        end
    end

    // ---------------- stage 2: column top read-modify-write ----------------
    col_entry_t col_mem [FRAME_COLS];
    col_entry_t top_rd_reg;
    col_entry_t fwd_val_reg;
    logic       fwd_hit_reg;
    col_entry_t top_cur;
    col_entry_t top_old;
    col_entry_t top_wdata;
    logic       top_we;
    logic       blank;
    logic [23:0] colour;
    logic [31:0] result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            // write to the column being read at the same edge: carry the new entry
            fwd_hit_reg  <= top_we && s1_valid_reg && (s1_col_idx == s2_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_action_reg <= s1_action_reg;
            s2_inside_reg <= s1_inside;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_idx;
            s2_code_reg   <= s1_code;
            fwd_val_reg   <= top_wdata;
        end
    end

    // Column memory, registered read
    always_ff @(posedge clk)
    begin
        if (adv && top_we)
        begin
            col_mem[s2_col_reg] <= top_wdata;
        end
        if (adv && s1_valid_reg && s1_inside)
        begin
            top_rd_reg <= col_mem[s1_col_idx];
        end
    end

    assign top_cur = fwd_hit_reg ? fwd_val_reg : top_rd_reg;

    // Row 0 restarts the column; a class-0 match can only raise the top
    always_comb
    begin
        top_old = top_cur;
        if (s2_row_reg == 8'd0)
        begin
            top_old.valid = 1'b0;
        end
        top_wdata = top_old;
        top_we    = 1'b0;
        if (s2_valid_reg && (s2_action_reg == ACT_WRITE) && s2_inside_reg)
        begin
            if ((s2_code_reg == 3'd1) && (!top_old.valid || (s2_row_reg < top_old.top)))
            begin
                top_wdata.valid = 1'b1;
                top_wdata.top   = s2_row_reg;
                top_we          = 1'b1;
            end
            else if (s2_row_reg == 8'd0)
            begin
                top_we = 1'b1;
            end
        end
    end

    // Read result: blank above the column top, zero outside the frame
    assign blank  = top_cur.valid && (s2_row_reg < top_cur.top);
    assign colour = colour_of(pix_rd_reg);

    always_comb
    begin
        result = 32'd0;
        if (s2_inside_reg && !blank && (pix_rd_reg inside {[3'd1:CODE_MAX]}))
        begin
            result = {5'd0, colour, pix_rd_reg};
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv && s2_valid_reg && (s2_action_reg == ACT_READ))
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg && (s2_action_reg == ACT_READ))
        begin
            m_data_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ---------------- assertions ----------------
    `DCPC_ASSERT_NOW(a_fwd_needs_item, fwd_hit_reg, s2_valid_reg)
    `DCPC_ASSERT_NOW(a_top_we_only_write,
        top_we, s2_valid_reg && (s2_action_reg == ACT_WRITE) && s2_inside_reg)
    `DCPC_ASSERT_NEXT(a_read_reaches_output,
        adv && s2_valid_reg && (s2_action_reg == ACT_READ), m_axis_tvalid)
    `DCPC_ASSERT_NOW(a_no_code_no_colour,
        m_axis_tvalid && (m_axis_tdata[2:0] == CODE_NONE), m_axis_tdata[31:3] == 29'd0)

endmodule
